[hw/rtl/bpq_pkg.sv]
// Shared types and codes for the bounded priority queue.
`timescale 1ns / 1ps
package bpq_pkg;

  localparam int PRIO_W   = 8;
  localparam int HANDLE_W = 32;
  localparam int DELAY_W  = 16;
  localparam int CLIENT_W = 10;
  localparam int CAP_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
    logic [DELAY_W-1:0]  delay;
    logic [CLIENT_W-1:0] client;
  } entry_t;

  // row-wide command seen by every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_op_t;

endpackage

[hw/rtl/bpq_cell.sv]
// One cell of the sorted entry row: holds one entry, shifts toward its neighbors.
`timescale 1ns / 1ps
module bpq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic              clk,
  input  bpq_pkg::cell_op_t op,
  input  logic [CW-1:0]     count,
  input  bpq_pkg::entry_t   new_entry,
  input  bpq_pkg::entry_t   left_entry,
  input  logic              left_ge,
  input  bpq_pkg::entry_t   right_entry,
  output bpq_pkg::entry_t   entry,
  output logic              ge
);
  import bpq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occupied;

  assign occupied = CW'(IDX) < count;
  // ties stay ahead of a newcomer, so the earliest arrival wins among equals
  assign ge       = occupied && (entry_r.prio >= new_entry.prio);
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (op.pop) begin
      entry_nxt = right_entry;
    end else if (op.push && !ge) begin
      if (left_ge) begin
        entry_nxt = new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[hw/rtl/bounded_priority_queue_unit.sv]
// A result appears on the output register in the cycle after its command transfers.
// Throughput: one command per cycle while no result stalls; the whole cell row updates
// at a single clock edge, and the head cell always holds the entry to be taken next.
// Reset: synchronous, active low; clears the entry count, the output valid and sets
// capacity to 16. Cell contents are not cleared.
`timescale 1ns / 1ps
module bounded_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic [bpq_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic [bpq_pkg::HANDLE_W-1:0] in_request_handle,
  input  logic [bpq_pkg::DELAY_W-1:0]  in_delay,
  input  logic [bpq_pkg::CLIENT_W-1:0] in_client_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bpq_pkg::STATUS_W-1:0] out_status,
  output logic [bpq_pkg::PRIO_W-1:0]   out_priority,
  output logic [bpq_pkg::HANDLE_W-1:0] out_handle,
  output logic [bpq_pkg::DELAY_W-1:0]  out_delay,
  output logic [bpq_pkg::CLIENT_W-1:0] out_client,
  input  logic                         cfg_we,
  input  logic [bpq_pkg::CAP_W-1:0]    cfg_wdata
);
  import bpq_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0]    cap_r;
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       cnt_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  entry_t              res_r;
  entry_t              res_nxt;

  logic     xfer;
  logic     is_add;
  logic     full;
  logic     empty;
  cell_op_t op;
  entry_t   new_entry;
  entry_t   cell_q [DEPTH];
  logic     ge     [DEPTH];

  assign in_ready  = !out_valid_r || out_ready;
  assign xfer      = in_valid && in_ready;
  assign is_add    = (in_cmd == CMD_ADD);
  assign full      = (CMPW'(cnt_r) >= CMPW'(cap_r)) || (cnt_r == CW'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign op.push   = xfer && is_add && !full;
  assign op.pop    = xfer && !is_add && !empty;
  assign new_entry = '{prio: in_priority_req, handle: in_request_handle,
                       delay: in_delay, client: in_client_id};

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t left_e;
      entry_t right_e;
      logic   left_ge;
      if (gi == 0) begin : g_head
        assign left_e  = new_entry;
        assign left_ge = 1'b1;
      end else begin : g_body
        assign left_e  = cell_q[gi-1];
        assign left_ge = ge[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign right_e = cell_q[gi];
      end else begin : g_mid
        assign right_e = cell_q[gi+1];
      end
      bpq_cell #(.IDX(gi), .CW(CW)) u_cell (
        .clk         (clk),
        .op          (op),
        .count       (cnt_r),
        .new_entry   (new_entry),
        .left_entry  (left_e),
        .left_ge     (left_ge),
        .right_entry (right_e),
        .entry       (cell_q[gi]),
        .ge          (ge[gi])
      );
    end
  endgenerate

  always_comb begin
    cnt_nxt = cnt_r;
    if (op.push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (op.pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    res_nxt       = res_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (xfer) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      priority if (is_add) begin
        status_nxt = full ? STATUS_FULL : STATUS_OK;
      end else if (empty) begin
        status_nxt = STATUS_EMPTY;
      end else begin
        status_nxt = STATUS_OK;
        res_nxt    = cell_q[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the payload while a result waits
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_priority = res_r.prio;
  assign out_handle   = res_r.handle;
  assign out_delay    = res_r.delay;
  assign out_client   = res_r.client;

endmodule

[hw/rtl/bpq_checker.sv]
// Port-level checks for the bounded priority queue, bound to the top level.
`timescale 1ns / 1ps
module bpq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bpq_pkg::STATUS_W-1:0] out_status,
  input logic [bpq_pkg::PRIO_W-1:0]   out_priority,
  input logic [bpq_pkg::HANDLE_W-1:0] out_handle,
  input logic [bpq_pkg::DELAY_W-1:0]  out_delay,
  input logic [bpq_pkg::CLIENT_W-1:0] out_client
);
  import bpq_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_transfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted command produced no result");

  a_non_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |->
      out_priority == '0 && out_handle == '0 && out_delay == '0 && out_client == '0)
    else $error("full or empty result carries entry data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_handle))
    else $error("stalled result changed");

endmodule

bind bounded_priority_queue_unit bpq_checker u_bpq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_priority (out_priority),
  .out_handle   (out_handle),
  .out_delay    (out_delay),
  .out_client   (out_client)
);
